[sv/eaq_pkg.sv]
// shared constants and helpers for the euler angle to quaternion converter
package eaq_pkg;

  localparam int TRIG_STAGES_DEF = 14;
  localparam int ATAN_ENTRIES    = 24;
  localparam int ANG_W           = 16;
  localparam int Q_W             = 16;
  localparam int CW              = 34;  // cordic datapath width
  localparam int TW              = 32;  // trig result width, q.30
  localparam int PW              = 64;  // product width

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [Q_W+2:0] Q14_ONE    = 19'sd16384;

  // arctangent of 2^-i in q.30
  function automatic logic signed [CW-1:0] atan_q30(input int idx);
    logic [31:0] v;
    begin
      unique case (idx)
        0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
        3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
        6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
        9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
        12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
        15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
        18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
        21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
        default: v = 32'h0;
      endcase
      atan_q30 = $signed({2'b00, v});
    end
  endfunction

  // round half up to q1.14 and clamp to plus or minus one
  function automatic logic signed [Q_W-1:0] to_q14(input logic signed [PW:0] s);
    logic signed [PW:0]    r;
    logic signed [Q_W+2:0] q;
    begin
      r = s + (65'sd1 <<< 45);
      q = r[PW:46];
      if (q > Q14_ONE)       q = Q14_ONE;
      else if (q < -Q14_ONE) q = -Q14_ONE;
      to_q14 = q[Q_W-1:0];
    end
  endfunction

endpackage

[sv/euler_angles_to_quaternion.sv]
// top level: zyx euler angles to attitude quaternion
// Takes one angle word (roll, pitch, yaw, Q3.13 radians) on every cycle that
// start is high; busy is always low. Each word gives one quaternion word
// (Q1.14, rounded, clamped to plus or minus one) on the quat ports with done
// high for one cycle, after one fold stage, TRIG_STAGES cordic stages (capped
// at ATAN_ENTRIES) and one sign stage in three parallel lanes, then three merge
// stages of multipliers. The receiver cannot stall the output.
module euler_angles_to_quaternion #(
  parameter int TRIG_STAGES = eaq_pkg::TRIG_STAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [eaq_pkg::ANG_W-1:0] roll_angle,
  input  logic signed [eaq_pkg::ANG_W-1:0] pitch_angle,
  input  logic signed [eaq_pkg::ANG_W-1:0] yaw_angle,
  output logic                            done,
  output logic signed [eaq_pkg::Q_W-1:0]   quat_scalar,
  output logic signed [eaq_pkg::Q_W-1:0]   quat_x,
  output logic signed [eaq_pkg::Q_W-1:0]   quat_y,
  output logic signed [eaq_pkg::Q_W-1:0]   quat_z
);
  import eaq_pkg::*;

  localparam int NS  = (TRIG_STAGES < ATAN_ENTRIES) ? TRIG_STAGES : ATAN_ENTRIES;
  localparam int LAT = NS + 5;

  logic signed [TW-1:0] cr, sr, cp, sp, cy, sy;
  logic [LAT-1:0]       vld;

  assign busy = 1'b0;

  // one lane per angle
  eaq_cordic_lane #(.STAGES(TRIG_STAGES)) u_roll (
    .clk(clk), .angle(roll_angle), .cos_out(cr), .sin_out(sr));
  eaq_cordic_lane #(.STAGES(TRIG_STAGES)) u_pitch (
    .clk(clk), .angle(pitch_angle), .cos_out(cp), .sin_out(sp));
  eaq_cordic_lane #(.STAGES(TRIG_STAGES)) u_yaw (
    .clk(clk), .angle(yaw_angle), .cos_out(cy), .sin_out(sy));

  eaq_merge u_merge (
    .clk(clk), .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
    .quat_scalar(quat_scalar), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z));

  // valid tracking along the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  assign done = vld[LAT-1];

endmodule

[sv/eaq_cordic_lane.sv]
// one pipelined cordic lane: sine and cosine of half the input angle
module eaq_cordic_lane #(
  parameter int STAGES = 14
) (
  input  logic                               clk,
  input  logic signed [eaq_pkg::ANG_W-1:0]   angle,
  output logic signed [eaq_pkg::TW-1:0]      cos_out,
  output logic signed [eaq_pkg::TW-1:0]      sin_out
);
  import eaq_pkg::*;

  localparam int NS = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;

  logic signed [CW-1:0] x [0:NS];
  logic signed [CW-1:0] y [0:NS];
  logic signed [CW-1:0] z [0:NS];
  logic                 flip [0:NS];
  logic signed [CW-1:0] z_in;

  // half angle widened to q.30
  assign z_in = $signed({{(CW-ANG_W-16){angle[ANG_W-1]}}, angle, 16'h0000});

  // quadrant fold
  always_ff @(posedge clk) begin
    x[0] <= CORDIC_GAIN;
    y[0] <= '0;
    if (z_in > HALF_PI_Q30) begin
      z[0] <= z_in - PI_Q30;
      flip[0] <= 1'b1;
    end else if (z_in < -HALF_PI_Q30) begin
      z[0] <= z_in + PI_Q30;
      flip[0] <= 1'b1;
    end else begin
      z[0] <= z_in;
      flip[0] <= 1'b0;
    end
  end

  // rotation stages
  for (genvar i = 0; i < NS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      flip[i+1] <= flip[i];
      if (!z[i][CW-1]) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - atan_q30(i);
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + atan_q30(i);
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk) begin
    if (flip[NS]) begin
      cos_out <= TW'(-x[NS]);
      sin_out <= TW'(-y[NS]);
    end else begin
      cos_out <= TW'(x[NS]);
      sin_out <= TW'(y[NS]);
    end
  end

endmodule

[sv/eaq_merge.sv]
// merge stage: triple products of the lane results into the quaternion
module eaq_merge (
  input  logic                          clk,
  input  logic signed [eaq_pkg::TW-1:0] cr, sr, cp, sp, cy, sy,
  output logic signed [eaq_pkg::Q_W-1:0] quat_scalar,
  output logic signed [eaq_pkg::Q_W-1:0] quat_x,
  output logic signed [eaq_pkg::Q_W-1:0] quat_y,
  output logic signed [eaq_pkg::Q_W-1:0] quat_z
);
  import eaq_pkg::*;

  logic signed [PW-1:0] m_cc, m_ss, m_sc, m_cs;
  logic signed [TW-1:0] a_cc, a_ss, a_sc, a_cs, a_cy, a_sy;
  logic signed [PW-1:0] t0, t1, t2, t3, t4, t5, t6, t7;

  assign m_cc = cr * cp;
  assign m_ss = sr * sp;
  assign m_sc = sr * cp;
  assign m_cs = cr * sp;

  // roll by pitch products, back to q.30
  always_ff @(posedge clk) begin
    a_cc <= TW'(m_cc >>> 30);
    a_ss <= TW'(m_ss >>> 30);
    a_sc <= TW'(m_sc >>> 30);
    a_cs <= TW'(m_cs >>> 30);
    a_cy <= cy;
    a_sy <= sy;
  end

  // times yaw terms
  always_ff @(posedge clk) begin
    t0 <= a_cc * a_cy;
    t1 <= a_ss * a_sy;
    t2 <= a_sc * a_cy;
    t3 <= a_cs * a_sy;
    t4 <= a_cs * a_cy;
    t5 <= a_sc * a_sy;
    t6 <= a_cc * a_sy;
    t7 <= a_ss * a_cy;
  end

  // sum, round and clamp into the output word
  always_ff @(posedge clk) begin
    quat_scalar <= to_q14((PW+1)'(t0) + (PW+1)'(t1));
    quat_x      <= to_q14((PW+1)'(t2) - (PW+1)'(t3));
    quat_y      <= to_q14((PW+1)'(t4) + (PW+1)'(t5));
    quat_z      <= to_q14((PW+1)'(t6) - (PW+1)'(t7));
  end

endmodule

[bench/euler_angles_to_quaternion_tb.sv]
// testbench for the zyx euler angle to quaternion converter
module euler_angles_to_quaternion_tb;
  import eaq_pkg::*;

  localparam int STAGES  = TRIG_STAGES_DEF;
  localparam int LATENCY = STAGES + 5;
  localparam int LIMIT   = 400000;

  typedef struct packed {
    logic signed [ANG_W-1:0] roll;
    logic signed [ANG_W-1:0] pitch;
    logic signed [ANG_W-1:0] yaw;
  } angles_t;

  typedef struct packed {
    logic signed [Q_W-1:0] w;
    logic signed [Q_W-1:0] x;
    logic signed [Q_W-1:0] y;
    logic signed [Q_W-1:0] z;
  } quat_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [ANG_W-1:0] roll_angle = '0, pitch_angle = '0, yaw_angle = '0;
  logic done;
  logic signed [Q_W-1:0] quat_scalar, quat_x, quat_y, quat_z;

  angles_t pending_angles[$];
  quat_t   expected_quats[$];
  int      idle_pct = 0;
  int      mismatches = 0;
  int      cycles = 0;
  bit      stim_done = 0;

  euler_angles_to_quaternion DUT (
    .clk, .rst, .start, .busy, .roll_angle, .pitch_angle, .yaw_angle,
    .done, .quat_scalar, .quat_x, .quat_y, .quat_z
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // atan of 2^-i, q.30
  function automatic longint atan_entry(input int i);
    longint tbl[24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
      64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return tbl[i];
  endfunction

  // cosine and sine of half the q3.13 angle, q.30
  function automatic void half_angle_trig(input logic signed [ANG_W-1:0] ang,
                                          output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * 65536;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 1686629713) begin
      z -= 64'sd3373259426;
      flip = 1;
    end else if (z < -1686629713) begin
      z += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint prod3(input longint a, b, c);
    return ((a * b) >>> 30) * c;
  endfunction

  function automatic logic signed [Q_W-1:0] round_q14(input longint v);
    longint r;
    r = (v + (64'sd1 <<< 45)) >>> 46;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[Q_W-1:0];
  endfunction

  function automatic quat_t attitude_of(input angles_t a);
    longint cr, sr, cp, sp, cy, sy;
    quat_t q;
    half_angle_trig(a.roll, cr, sr);
    half_angle_trig(a.pitch, cp, sp);
    half_angle_trig(a.yaw, cy, sy);
    q.w = round_q14(prod3(cr, cp, cy) + prod3(sr, sp, sy));
    q.x = round_q14(prod3(sr, cp, cy) - prod3(cr, sp, sy));
    q.y = round_q14(prod3(cr, sp, cy) + prod3(sr, cp, sy));
    q.z = round_q14(prod3(cr, cp, sy) - prod3(sr, sp, cy));
    return q;
  endfunction

  function automatic logic signed [ANG_W-1:0] rand_angle();
    case ($urandom_range(0, 9))
      0: return 16'($urandom());  // any bit pattern
      1: return $urandom_range(0, 1) ? 16'sd25736 : -16'sd25736;
      2: return 16'($urandom_range(12868 - 40, 12868 + 40) *
                    ($urandom_range(0, 1) ? 1 : -1));
      default: return $signed(16'($urandom_range(0, 51472))) - 16'sd25736;
    endcase
  endfunction

  // driver: one word per accepted start
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (start && !busy) expected_quats.push_back(attitude_of({roll_angle,
          pitch_angle, yaw_angle}));
      if ((!start || !busy) && pending_angles.size() > 0 &&
          $urandom_range(0, 99) >= idle_pct) begin
        angles_t a;
        a = pending_angles.pop_front();
        start <= 1;
        roll_angle <= a.roll;
        pitch_angle <= a.pitch;
        yaw_angle <= a.yaw;
      end else if (!start || !busy) begin
        start <= 0;
      end
    end
  end

  // monitor: compare each quaternion word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      quat_t exp_q, got;
      got = {quat_scalar, quat_x, quat_y, quat_z};
      if (expected_quats.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected word %h", got);
      end else begin
        exp_q = expected_quats.pop_front();
        if (got !== exp_q) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                     exp_q.w, exp_q.x, exp_q.y, exp_q.z, got.w, got.x, got.y, got.z);
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int extremes[7] = '{0, 1, -1, 25736, -25736, 32767, -32768};
    int pcts[4] = '{0, 75, 0, 26};
    repeat (7) @(posedge clk);
    rst <= 0;
    // directed corners, including angles past the fold and raw extremes
    foreach (extremes[i]) begin
      pending_angles.push_back({16'(extremes[i]), 16'sd0, 16'sd0});
      pending_angles.push_back({16'sd0, 16'(extremes[i]), 16'sd0});
      pending_angles.push_back({16'sd0, 16'sd0, 16'(extremes[i])});
    end
    pending_angles.push_back({16'sd25736, 16'sd25736, 16'sd25736});
    pending_angles.push_back({-16'sd32768, 16'sd32767, -16'sd32768});
    pending_angles.push_back({16'sd12868, -16'sd12868, 16'sd12869});
    wait (pending_angles.size() == 0);
    // random phases with varying sender gaps
    foreach (pcts[p]) begin
      idle_pct = pcts[p];
      for (int k = 0; k < 360; k++)
        pending_angles.push_back({rand_angle(), rand_angle(), rand_angle()});
      wait (pending_angles.size() == 0);
    end
    @(posedge clk);
    while (expected_quats.size() > 0 || start) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatches == 0 && expected_quats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
